/* hw/rtl/decimal_money_text_parser_core_defines.svh */
// Assertion macros used by the checker of the money text parser.
`ifndef DECIMAL_MONEY_TEXT_PARSER_CORE_DEFINES_SVH
`define DECIMAL_MONEY_TEXT_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define DMTP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define DMTP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/dmtp_pkg.sv */
// Shared token type and character class codes of the money text parser.
package dmtp_pkg;

	localparam logic [2:0] KIND_DIGIT = 3'd0;
	localparam logic [2:0] KIND_BLANK = 3'd1;
	localparam logic [2:0] KIND_PLUS  = 3'd2;
	localparam logic [2:0] KIND_MINUS = 3'd3;
	localparam logic [2:0] KIND_SEP   = 3'd4;
	localparam logic [2:0] KIND_TERM  = 3'd5;
	localparam logic [2:0] KIND_OTHER = 3'd6;

	// One classified character as it travels from the front to the back.
	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] digit;
	} token_t;

endpackage

/* hw/rtl/dmtp_front.sv */
// Front end: classifies one character byte into a parser token.
module dmtp_front (
	input  logic [7:0]      char_code,
	output dmtp_pkg::token_t token
);
	import dmtp_pkg::*;

	always_comb begin
		token.digit = char_code[3:0];
		unique case (char_code) inside
			8'h00:                 token.kind = KIND_TERM;
			[8'h09:8'h0d], 8'h20:  token.kind = KIND_BLANK;
			8'h2b:                 token.kind = KIND_PLUS;
			8'h2d:                 token.kind = KIND_MINUS;
			8'h2c, 8'h2e:          token.kind = KIND_SEP;
			[8'h30:8'h39]:         token.kind = KIND_DIGIT;
			default:               token.kind = KIND_OTHER;
		endcase
	end

endmodule

/* hw/rtl/dmtp_queue.sv */
// Two-entry token queue between the classifying front and the parsing back.
module dmtp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dmtp_pkg::token_t push_token,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output dmtp_pkg::token_t head
);
	import dmtp_pkg::*;

	token_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full      = count_q[1];
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

endmodule

/* hw/rtl/dmtp_back.sv */
// Back end: grammar state machine, cents accumulator and result register.
module dmtp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  dmtp_pkg::token_t   head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               ok,
	output logic signed [63:0] cents
);
	import dmtp_pkg::*;

	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_INT    = 3'd2;
	localparam logic [2:0] PH_SEP    = 3'd3;
	localparam logic [2:0] PH_FRAC1  = 3'd4;
	localparam logic [2:0] PH_FRAC2  = 3'd5;
	localparam logic [2:0] PH_TRAIL  = 3'd6;
	localparam logic [2:0] PH_ERROR  = 3'd7;

	localparam logic [70:0] LIMIT_POS = {8'd0, {63{1'b1}}};
	localparam logic [70:0] LIMIT_NEG = {7'd0, 1'b1, 63'd0};

	logic [2:0]  phase_q, phase_d;
	logic        negative_q, negative_d;
	logic [63:0] int_q, int_d;
	logic [6:0]  frac_q, frac_d;
	logic        result_valid_q;
	logic        ok_q;
	logic [63:0] cents_q;

	logic        is_term;
	logic        out_free;
	logic        take;
	logic        complete;
	logic        good;
	logic [67:0] prod;
	logic [70:0] mag;
	logic [63:0] value;

	assign is_term  = (head.kind == KIND_TERM);
	assign out_free = !result_valid_q || !result_stall;
	assign pop      = head_valid && (!is_term || out_free);

	// Next integer value: x*10 + d; the upper four bits flag an overflow.
	assign prod = ({4'd0, int_q} << 3) + ({4'd0, int_q} << 1) + {64'd0, head.digit};

	// Final magnitude in cents: x*100 + fraction.
	assign mag = ({7'd0, int_q} << 6) + ({7'd0, int_q} << 5) + ({7'd0, int_q} << 2)
		+ {64'd0, frac_q};

	assign complete = (phase_q == PH_INT) || (phase_q == PH_FRAC1)
		|| (phase_q == PH_FRAC2) || (phase_q == PH_TRAIL);
	assign good  = complete && (mag <= (negative_q ? LIMIT_NEG : LIMIT_POS));
	assign value = negative_q ? (64'd0 - mag[63:0]) : mag[63:0];

	always_comb begin
		phase_d    = phase_q;
		negative_d = negative_q;
		int_d      = int_q;
		frac_d     = frac_q;
		take       = 1'b0;
		unique case (phase_q) inside
			PH_LEAD: begin
				if (head.kind == KIND_BLANK) begin
					phase_d = PH_LEAD;
				end else if (head.kind == KIND_PLUS || head.kind == KIND_MINUS) begin
					negative_d = (head.kind == KIND_MINUS);
					phase_d    = PH_SIGNED;
				end else if (head.kind == KIND_DIGIT) begin
					take = 1'b1;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_SIGNED: begin
				if (head.kind == KIND_DIGIT) begin
					take = 1'b1;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_INT: begin
				if (head.kind == KIND_DIGIT) begin
					take = 1'b1;
				end else if (head.kind == KIND_SEP) begin
					phase_d = PH_SEP;
				end else if (head.kind == KIND_BLANK) begin
					phase_d = PH_TRAIL;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_SEP: begin
				if (head.kind == KIND_DIGIT) begin
					frac_d  = ({3'd0, head.digit} << 3) + ({3'd0, head.digit} << 1);
					phase_d = PH_FRAC1;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_FRAC1: begin
				if (head.kind == KIND_DIGIT) begin
					frac_d  = frac_q + {3'd0, head.digit};
					phase_d = PH_FRAC2;
				end else if (head.kind == KIND_BLANK) begin
					phase_d = PH_TRAIL;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_FRAC2, PH_TRAIL: begin
				phase_d = (head.kind == KIND_BLANK) ? PH_TRAIL : PH_ERROR;
			end
			default: begin
				phase_d = PH_ERROR;
			end
		endcase
		if (take) begin
			if (|prod[67:64]) begin
				phase_d = PH_ERROR;
			end else begin
				int_d   = prod[63:0];
				phase_d = PH_INT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_LEAD;
			negative_q     <= 1'b0;
			int_q          <= 64'd0;
			frac_q         <= 7'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (pop) begin
				if (is_term) begin
					phase_q        <= PH_LEAD;
					negative_q     <= 1'b0;
					int_q          <= 64'd0;
					frac_q         <= 7'd0;
					result_valid_q <= 1'b1;
				end else begin
					phase_q    <= phase_d;
					negative_q <= negative_d;
					int_q      <= int_d;
					frac_q     <= frac_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_term) begin
			ok_q    <= good;
			cents_q <= good ? value : 64'd0;
		end
	end

	assign result_valid = result_valid_q;
	assign ok           = ok_q;
	assign cents        = cents_q;

endmodule

/* hw/rtl/decimal_money_text_parser_core.sv */
// Top level of the money text parser: front classifier, token queue and parsing back end.
//
// The char channel (char_valid, char_stall, char_code) carries one text byte per
// transaction. A zero byte ends the string; it alone causes a transaction on the
// result channel (result_valid, result_stall, ok, cents). cents is the signed amount
// in cents, or zero when ok is low because of a syntax fault or an amount outside
// the signed 64-bit range.
//
// Throughput is one character per cycle while char_stall is low: the front classifies a
// byte in the cycle it arrives, and the back runs one grammar step and one shift-add on
// its 64-bit accumulator per cycle. A terminator passes through the token queue into the
// result register when at the head with the register free; that sets result_valid.
//
// When the receiver holds result_stall, the result register keeps its transaction;
// characters keep flowing until a terminator reaches the head of the queue, after
// which the queue fills and char_stall rises. char_stall is simply the queue being
// full, and it is never high while the result register is empty.
//
// Asynchronous reset (arst_n low) empties the queue and the result register and
// returns the parser to expecting leading whitespace, a sign or a digit.
module decimal_money_text_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_code,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               ok,
	output logic signed [63:0] cents
);
	import dmtp_pkg::*;

	token_t front_token;
	token_t head_token;
	logic   q_full;
	logic   q_not_empty;
	logic   q_push;
	logic   q_pop;

	// A character transaction completes whenever the queue has room.
	assign q_push     = char_valid && !q_full;
	assign char_stall = q_full;

	dmtp_front u_front (
		.char_code (char_code),
		.token     (front_token)
	);

	dmtp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_token (front_token),
		.pop        (q_pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (head_token)
	);

	// The back end only holds a token back when it is a terminator and the result
	// register is still occupied by a stalled transaction.
	dmtp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_not_empty),
		.head         (head_token),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ok           (ok),
		.cents        (cents)
	);

endmodule

/* hw/rtl/dmtp_checker.sv */
// Port-level assertions of the money text parser and their bind to the top level.
`include "decimal_money_text_parser_core_defines.svh"

module dmtp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               char_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic               ok,
	input logic signed [63:0] cents
);

	// A failed parse always reports a zero amount.
	`DMTP_ASSERT_IMP(a_fail_zero, result_valid && !ok, cents == 64'sd0, "failed result with nonzero cents")

	// A stalled result transaction holds its payload.
	`DMTP_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(ok) && $stable(cents), "stalled result changed")

	// The input side only backs up behind a waiting result.
	`DMTP_ASSERT_IMP(a_stall_cause, !result_valid, !char_stall, "char_stall with empty result register")

endmodule

bind decimal_money_text_parser_core dmtp_checker u_checker (.*);
